// File: hw/rtl/gpcc_pkg.sv
// ----------------------------------------------------------------------------
// gpcc_pkg
// Shared widths, types and helper functions of the genotype pair
// contingency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcc_pkg;

  // Sizing
  localparam int WORD_BITS   = 64;  // counted bits of each bit-plane word
  localparam int COUNT_BITS  = 20;  // accumulator and cell precision
  localparam int PLANE_BITS  = 64;  // bit-plane field width on the port
  localparam int FIELD_BITS  = 20;  // marginal and cell field width on the port
  localparam int GROUP_BITS  = 2;
  localparam int PC_BITS     = $clog2(WORD_BITS + 1);
  localparam int NUM_LANES   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Lane indexes of the joint popcounts
  localparam int LANE_A0_B0 = 0;
  localparam int LANE_A0_B1 = 1;
  localparam int LANE_A1_B0 = 2;
  localparam int LANE_A1_B1 = 3;

  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [PLANE_BITS-1:0]   plane_t;
  typedef logic [FIELD_BITS-1:0]   field_t;
  typedef logic [GROUP_BITS-1:0]   group_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [COUNT_BITS+1:0]   diff_t;
  typedef logic [PC_BITS-1:0]      pc_t;
  typedef logic [QCNT_BITS-1:0]    qcnt_t;
  typedef logic [QPTR_BITS-1:0]    qptr_t;

  localparam count_t CNT_MAX = {COUNT_BITS{1'b1}};

  // Classified word, as it waits in the queue
  typedef struct packed {
    group_t                 group;
    logic                   last;
    pc_t [NUM_LANES-1:0]    pc;
    count_t                 a_tot0;
    count_t                 a_tot1;
    count_t                 a_tot2;
    count_t                 b_tot0;
    count_t                 b_tot1;
  } item_t;

  // Finished accumulator set of one group, waiting for fill-in
  typedef struct packed {
    group_t                 group;
    logic                   sat;
    count_t [NUM_LANES-1:0] acc;
    count_t                 a_tot0;
    count_t                 a_tot1;
    count_t                 a_tot2;
    count_t                 b_tot0;
    count_t                 b_tot1;
  } tbl_t;

  // Output register contents
  typedef struct packed {
    group_t group;
    field_t c00;
    field_t c01;
    field_t c02;
    field_t c10;
    field_t c11;
    field_t c12;
    field_t c20;
    field_t c21;
    field_t c22;
    logic   inconsistent;
  } out_t;

  typedef struct packed {
    logic  full;
    qcnt_t count;
  } q_stat_t;

  typedef struct packed {
    logic tbl_valid;
    logic acc_clear;
  } back_stat_t;

  // Number of set bits in one word
  function automatic pc_t popcount(word_t w);
    pc_t n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + pc_t'(w[i]);
    end
    return n;
  endfunction

  // Port field to count precision: keep the low COUNT_BITS bits
  function automatic count_t to_count(field_t v);
    logic [COUNT_BITS+FIELD_BITS-1:0] w;
    w = {{COUNT_BITS{1'b0}}, v};
    return w[COUNT_BITS-1:0];
  endfunction

  // Count to port field width
  function automatic field_t to_field(count_t c);
    logic [COUNT_BITS+FIELD_BITS-1:0] w;
    w = {{FIELD_BITS{1'b0}}, c};
    return w[FIELD_BITS-1:0];
  endfunction

  // total - x - y in two's complement; top bit set means negative
  function automatic diff_t fill_diff(count_t total, count_t x, count_t y);
    return {2'b00, total} - {2'b00, x} - {2'b00, y};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gpcc_in_if.sv
// ----------------------------------------------------------------------------
// gpcc_in_if
// Word channel: one transaction carries one set of four bit-plane words.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpcc_in_if;
  logic              valid;
  logic              ready;
  gpcc_pkg::group_t  group;
  gpcc_pkg::plane_t  a_geno0_word;
  gpcc_pkg::plane_t  a_geno1_word;
  gpcc_pkg::plane_t  b_geno0_word;
  gpcc_pkg::plane_t  b_geno1_word;
  logic              last_word;
  gpcc_pkg::field_t  a_total_g0;
  gpcc_pkg::field_t  a_total_g1;
  gpcc_pkg::field_t  a_total_g2;
  gpcc_pkg::field_t  b_total_g0;
  gpcc_pkg::field_t  b_total_g1;

  modport source (
    output valid, group, a_geno0_word, a_geno1_word, b_geno0_word, b_geno1_word,
           last_word, a_total_g0, a_total_g1, a_total_g2, b_total_g0, b_total_g1,
    input  ready
  );

  modport sink (
    input  valid, group, a_geno0_word, a_geno1_word, b_geno0_word, b_geno1_word,
           last_word, a_total_g0, a_total_g1, a_total_g2, b_total_g0, b_total_g1,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/gpcc_out_if.sv
// ----------------------------------------------------------------------------
// gpcc_out_if
// Table channel: one transaction carries the nine cells of one group.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpcc_out_if;
  logic              valid;
  logic              ready;
  gpcc_pkg::group_t  out_group;
  gpcc_pkg::field_t  cell_00;
  gpcc_pkg::field_t  cell_01;
  gpcc_pkg::field_t  cell_02;
  gpcc_pkg::field_t  cell_10;
  gpcc_pkg::field_t  cell_11;
  gpcc_pkg::field_t  cell_12;
  gpcc_pkg::field_t  cell_20;
  gpcc_pkg::field_t  cell_21;
  gpcc_pkg::field_t  cell_22;
  logic              inconsistent;

  modport source (
    output valid, out_group, cell_00, cell_01, cell_02, cell_10, cell_11, cell_12,
           cell_20, cell_21, cell_22, inconsistent,
    input  ready
  );

  modport sink (
    input  valid, out_group, cell_00, cell_01, cell_02, cell_10, cell_11, cell_12,
           cell_20, cell_21, cell_22, inconsistent,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/gpcc_front.sv
// ----------------------------------------------------------------------------
// gpcc_front
// Accepts word transactions, forms the four joint popcounts and trims the
// marginal counts, then pushes the classified word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcc_front (
  gpcc_in_if.sink          in_if,
  input  logic             full_i,
  output logic             push_o,
  output gpcc_pkg::item_t  item_o
);

  gpcc_pkg::word_t a0, a1, b0, b1;

  // Only the low WORD_BITS of each plane count
  assign a0 = in_if.a_geno0_word[gpcc_pkg::WORD_BITS-1:0];
  assign a1 = in_if.a_geno1_word[gpcc_pkg::WORD_BITS-1:0];
  assign b0 = in_if.b_geno0_word[gpcc_pkg::WORD_BITS-1:0];
  assign b1 = in_if.b_geno1_word[gpcc_pkg::WORD_BITS-1:0];

  // Handshake: take a word whenever the queue has room
  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  // Classified word
  always_comb begin
    item_o.group                        = in_if.group;
    item_o.last                         = in_if.last_word;
    item_o.pc[gpcc_pkg::LANE_A0_B0]     = gpcc_pkg::popcount(a0 & b0);
    item_o.pc[gpcc_pkg::LANE_A0_B1]     = gpcc_pkg::popcount(a0 & b1);
    item_o.pc[gpcc_pkg::LANE_A1_B0]     = gpcc_pkg::popcount(a1 & b0);
    item_o.pc[gpcc_pkg::LANE_A1_B1]     = gpcc_pkg::popcount(a1 & b1);
    item_o.a_tot0                       = gpcc_pkg::to_count(in_if.a_total_g0);
    item_o.a_tot1                       = gpcc_pkg::to_count(in_if.a_total_g1);
    item_o.a_tot2                       = gpcc_pkg::to_count(in_if.a_total_g2);
    item_o.b_tot0                       = gpcc_pkg::to_count(in_if.b_total_g0);
    item_o.b_tot1                       = gpcc_pkg::to_count(in_if.b_total_g1);
  end

endmodule

`default_nettype wire

// File: hw/rtl/gpcc_queue.sv
// ----------------------------------------------------------------------------
// gpcc_queue
// Short register queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gpcc_pkg::item_t      item_i,
  input  logic                 pop_i,
  output gpcc_pkg::item_t      head_o,
  output logic                 head_valid_o,
  output gpcc_pkg::q_stat_t    stat_o
);

  localparam gpcc_pkg::qptr_t PTR_LAST = gpcc_pkg::qptr_t'(gpcc_pkg::QUEUE_DEPTH - 1);
  localparam gpcc_pkg::qcnt_t CNT_FULL = gpcc_pkg::qcnt_t'(gpcc_pkg::QUEUE_DEPTH);

  gpcc_pkg::item_t mem_q [gpcc_pkg::QUEUE_DEPTH];
  gpcc_pkg::qptr_t wr_ptr_q, wr_ptr_d;
  gpcc_pkg::qptr_t rd_ptr_q, rd_ptr_d;
  gpcc_pkg::qcnt_t count_q, count_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign stat_o.full  = (count_q == CNT_FULL);
  assign stat_o.count = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/gpcc_back.sv
// ----------------------------------------------------------------------------
// gpcc_back
// Saturating accumulation of the joint popcounts, fill-in of the cells
// that involve genotype 2, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gpcc_pkg::item_t        head_i,
  input  logic                   head_valid_i,
  output logic                   pop_o,
  output gpcc_pkg::back_stat_t   stat_o,
  gpcc_out_if.source             out_if
);

  gpcc_pkg::count_t acc_q [gpcc_pkg::NUM_LANES];
  gpcc_pkg::count_t acc_d [gpcc_pkg::NUM_LANES];
  gpcc_pkg::count_t acc_sum [gpcc_pkg::NUM_LANES];
  logic [gpcc_pkg::NUM_LANES-1:0] ovf;
  logic sat_q, sat_d, sat_next;

  gpcc_pkg::tbl_t tbl_q, tbl_d;
  logic           tbl_valid_q, tbl_valid_d;
  logic           tbl_move, tbl_free, close_grp;

  gpcc_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  // Stage handshakes
  assign tbl_move  = tbl_valid_q && (!out_valid_q || out_if.ready);
  assign tbl_free  = !tbl_valid_q || tbl_move;
  assign pop_o     = head_valid_i && (!head_i.last || tbl_free);
  assign close_grp = pop_o && head_i.last;

  // Saturating sums of the current word
  always_comb begin
    logic [gpcc_pkg::COUNT_BITS:0] sum;
    for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
      sum        = {1'b0, acc_q[k]} + (gpcc_pkg::COUNT_BITS + 1)'(head_i.pc[k]);
      ovf[k]     = sum[gpcc_pkg::COUNT_BITS];
      acc_sum[k] = ovf[k] ? gpcc_pkg::CNT_MAX : sum[gpcc_pkg::COUNT_BITS-1:0];
    end
    sat_next = sat_q || (|ovf);
  end

  // Accumulator update; the group's last word closes the table
  always_comb begin
    for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
      acc_d[k] = acc_q[k];
    end
    sat_d = sat_q;
    if (pop_o) begin
      for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
        acc_d[k] = head_i.last ? '0 : acc_sum[k];
      end
      sat_d = head_i.last ? 1'b0 : sat_next;
    end
  end

  // Closed table
  always_comb begin
    tbl_d.group  = head_i.group;
    tbl_d.sat    = sat_next;
    for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
      tbl_d.acc[k] = acc_sum[k];
    end
    tbl_d.a_tot0 = head_i.a_tot0;
    tbl_d.a_tot1 = head_i.a_tot1;
    tbl_d.a_tot2 = head_i.a_tot2;
    tbl_d.b_tot0 = head_i.b_tot0;
    tbl_d.b_tot1 = head_i.b_tot1;
    tbl_valid_d  = tbl_valid_q;
    if (tbl_move) begin
      tbl_valid_d = 1'b0;
    end
    if (close_grp) begin
      tbl_valid_d = 1'b1;
    end
  end

  // Fill-in from the marginals, negative results clamp to zero
  always_comb begin
    gpcc_pkg::diff_t  d02, d12, d20, d21, d22;
    gpcc_pkg::count_t c20, c21;
    logic             neg20, neg21;
    d02   = gpcc_pkg::fill_diff(tbl_q.a_tot0, tbl_q.acc[gpcc_pkg::LANE_A0_B0],
                                tbl_q.acc[gpcc_pkg::LANE_A0_B1]);
    d12   = gpcc_pkg::fill_diff(tbl_q.a_tot1, tbl_q.acc[gpcc_pkg::LANE_A1_B0],
                                tbl_q.acc[gpcc_pkg::LANE_A1_B1]);
    d20   = gpcc_pkg::fill_diff(tbl_q.b_tot0, tbl_q.acc[gpcc_pkg::LANE_A0_B0],
                                tbl_q.acc[gpcc_pkg::LANE_A1_B0]);
    d21   = gpcc_pkg::fill_diff(tbl_q.b_tot1, tbl_q.acc[gpcc_pkg::LANE_A0_B1],
                                tbl_q.acc[gpcc_pkg::LANE_A1_B1]);
    neg20 = d20[gpcc_pkg::COUNT_BITS+1];
    neg21 = d21[gpcc_pkg::COUNT_BITS+1];
    c20   = neg20 ? '0 : d20[gpcc_pkg::COUNT_BITS-1:0];
    c21   = neg21 ? '0 : d21[gpcc_pkg::COUNT_BITS-1:0];
    d22   = gpcc_pkg::fill_diff(tbl_q.a_tot2, c20, c21);

    out_d.group = tbl_q.group;
    out_d.c00   = gpcc_pkg::to_field(tbl_q.acc[gpcc_pkg::LANE_A0_B0]);
    out_d.c01   = gpcc_pkg::to_field(tbl_q.acc[gpcc_pkg::LANE_A0_B1]);
    out_d.c10   = gpcc_pkg::to_field(tbl_q.acc[gpcc_pkg::LANE_A1_B0]);
    out_d.c11   = gpcc_pkg::to_field(tbl_q.acc[gpcc_pkg::LANE_A1_B1]);
    out_d.c02   = gpcc_pkg::to_field(d02[gpcc_pkg::COUNT_BITS+1] ?
                                     '0 : d02[gpcc_pkg::COUNT_BITS-1:0]);
    out_d.c12   = gpcc_pkg::to_field(d12[gpcc_pkg::COUNT_BITS+1] ?
                                     '0 : d12[gpcc_pkg::COUNT_BITS-1:0]);
    out_d.c20   = gpcc_pkg::to_field(c20);
    out_d.c21   = gpcc_pkg::to_field(c21);
    out_d.c22   = gpcc_pkg::to_field(d22[gpcc_pkg::COUNT_BITS+1] ?
                                     '0 : d22[gpcc_pkg::COUNT_BITS-1:0]);
    out_d.inconsistent = tbl_q.sat || d02[gpcc_pkg::COUNT_BITS+1] ||
                         d12[gpcc_pkg::COUNT_BITS+1] || neg20 || neg21 ||
                         d22[gpcc_pkg::COUNT_BITS+1];
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (tbl_move) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
        acc_q[k] <= '0;
      end
      sat_q       <= 1'b0;
      tbl_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
        acc_q[k] <= acc_d[k];
      end
      sat_q       <= sat_d;
      tbl_valid_q <= tbl_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (close_grp) begin
      tbl_q <= tbl_d;
    end
    if (tbl_move) begin
      out_q <= out_d;
    end
  end

  // Status for checks
  always_comb begin
    stat_o.tbl_valid = tbl_valid_q;
    stat_o.acc_clear = !sat_q;
    for (int k = 0; k < gpcc_pkg::NUM_LANES; k++) begin
      if (acc_q[k] != '0) begin
        stat_o.acc_clear = 1'b0;
      end
    end
  end

  // Output channel
  assign out_if.valid        = out_valid_q;
  assign out_if.out_group    = out_q.group;
  assign out_if.cell_00      = out_q.c00;
  assign out_if.cell_01      = out_q.c01;
  assign out_if.cell_02      = out_q.c02;
  assign out_if.cell_10      = out_q.c10;
  assign out_if.cell_11      = out_q.c11;
  assign out_if.cell_12      = out_q.c12;
  assign out_if.cell_20      = out_q.c20;
  assign out_if.cell_21      = out_q.c21;
  assign out_if.cell_22      = out_q.c22;
  assign out_if.inconsistent = out_q.inconsistent;

endmodule

`default_nettype wire

// File: hw/rtl/genotype_pair_contingency_counter.sv
// ----------------------------------------------------------------------------
// genotype_pair_contingency_counter
// Joint 3x3 genotype count table of two markers, one table per sample group.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one transaction per 64-sample word: four bit-planes
//   (A genotype 0/1, B genotype 0/1), the group, a last-word flag and, on the
//   last word, the marginal counts of the group. out_chan carries one
//   transaction per group: the nine cells and an inconsistency flag.
//   Throughput is one word per cycle while the queue has room. The popcount
//   tree sits in the front, the 20-bit saturating accumulate in the back.
//   The table of a group reaches out_chan through the queue, the table stage
//   and the output register, after the edge that accepts its last word.
//   A two-entry queue decouples the front from the back; in_chan.ready drops
//   only while the queue is full. A receiver stall holds the output register,
//   then the closed table, then words in the queue; words that do not close
//   a group keep flowing into the accumulators while one table waits.
//   Reset clears the accumulators, the saturation flag, the queue and all
//   valid flags; no table is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module genotype_pair_contingency_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpcc_in_if.sink    in_chan,
  gpcc_out_if.source out_chan
);

  logic                  push, pop, head_valid;
  gpcc_pkg::item_t       push_item, head;
  gpcc_pkg::q_stat_t     q_stat;
  gpcc_pkg::back_stat_t  b_stat;

  gpcc_front u_front (
    .in_if  (in_chan),
    .full_i (q_stat.full),
    .push_o (push),
    .item_o (push_item)
  );

  gpcc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .stat_o       (q_stat)
  );

  gpcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .stat_o       (b_stat),
    .out_if       (out_chan)
  );

  // Checks
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= gpcc_pkg::qcnt_t'(gpcc_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_q_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (q_stat.count == $past(q_stat.count) - 1'b1))
    else $error("queue count did not drop on pop");

  a_close_tbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.last) |=> b_stat.tbl_valid)
    else $error("closed group left no pending table");

  a_close_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.last) |=> b_stat.acc_clear)
    else $error("accumulators not cleared after last word");

endmodule

`default_nettype wire

// File: verif/gpcc_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpcc_table_checker
// Watches the word and table channels of the contingency counter. It keeps
// its own joint-count tallies, predicts the table of every closed group and
// compares each table transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module gpcc_table_checker
  import gpcc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gpcc_in_if   in_mon,
  gpcc_out_if  out_mon,
  output int   err_count_o,
  output int   pending_o
);

  // Joint popcount tallies of the open group, indexed by lane
  count_t tally [NUM_LANES];
  logic   tally_sat;
  out_t   tables_due [$];
  int     errors  = 0;
  int     pending = 0;

  assign err_count_o = errors;
  assign pending_o   = pending;

  // total - x - y, held at zero when it goes negative
  function automatic count_t fill_cell(count_t total, count_t x, count_t y,
                                       inout logic neg);
    int d;
    d = int'(total) - int'(x) - int'(y);
    if (d < 0) begin
      neg = 1'b1;
      return '0;
    end
    return count_t'(d);
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t   due;
    out_t   table_out;
    word_t  a0, a1, b0, b1;
    int     pc [NUM_LANES];
    int     sum;
    logic   neg;
    count_t c02, c12, c20, c21, c22;
    if (!rst_ni) begin
      foreach (tally[l]) tally[l] = '0;
      tally_sat = 1'b0;
      tables_due.delete();
      pending = 0;
    end else begin
      // Table side: compare against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (tables_due.size() == 0) begin
          $error("table transaction with none expected, out_group %0d",
                 out_mon.out_group);
          errors++;
        end else begin
          due = tables_due.pop_front();
          compare_field("out_group", 32'(due.group), 32'(out_mon.out_group));
          compare_field("cell_00", 32'(due.c00), 32'(out_mon.cell_00));
          compare_field("cell_01", 32'(due.c01), 32'(out_mon.cell_01));
          compare_field("cell_02", 32'(due.c02), 32'(out_mon.cell_02));
          compare_field("cell_10", 32'(due.c10), 32'(out_mon.cell_10));
          compare_field("cell_11", 32'(due.c11), 32'(out_mon.cell_11));
          compare_field("cell_12", 32'(due.c12), 32'(out_mon.cell_12));
          compare_field("cell_20", 32'(due.c20), 32'(out_mon.cell_20));
          compare_field("cell_21", 32'(due.c21), 32'(out_mon.cell_21));
          compare_field("cell_22", 32'(due.c22), 32'(out_mon.cell_22));
          compare_field("inconsistent", 32'(due.inconsistent),
                        32'(out_mon.inconsistent));
        end
      end

      // Word side: saturating accumulate, then close the table on the last word
      if (in_mon.valid && in_mon.ready) begin
        a0 = word_t'(in_mon.a_geno0_word);
        a1 = word_t'(in_mon.a_geno1_word);
        b0 = word_t'(in_mon.b_geno0_word);
        b1 = word_t'(in_mon.b_geno1_word);
        pc[LANE_A0_B0] = $countones(a0 & b0);
        pc[LANE_A0_B1] = $countones(a0 & b1);
        pc[LANE_A1_B0] = $countones(a1 & b0);
        pc[LANE_A1_B1] = $countones(a1 & b1);
        for (int l = 0; l < NUM_LANES; l++) begin
          sum = int'(tally[l]) + pc[l];
          if (sum > int'(CNT_MAX)) begin
            tally[l]  = CNT_MAX;
            tally_sat = 1'b1;
          end else begin
            tally[l] = count_t'(sum);
          end
        end

        if (in_mon.last_word) begin
          neg = 1'b0;
          c02 = fill_cell(count_t'(in_mon.a_total_g0), tally[LANE_A0_B0],
                          tally[LANE_A0_B1], neg);
          c12 = fill_cell(count_t'(in_mon.a_total_g1), tally[LANE_A1_B0],
                          tally[LANE_A1_B1], neg);
          c20 = fill_cell(count_t'(in_mon.b_total_g0), tally[LANE_A0_B0],
                          tally[LANE_A1_B0], neg);
          c21 = fill_cell(count_t'(in_mon.b_total_g1), tally[LANE_A0_B1],
                          tally[LANE_A1_B1], neg);
          // last cell is derived from the already clamped cells
          c22 = fill_cell(count_t'(in_mon.a_total_g2), c20, c21, neg);

          table_out.group        = in_mon.group;
          table_out.c00          = field_t'(tally[LANE_A0_B0]);
          table_out.c01          = field_t'(tally[LANE_A0_B1]);
          table_out.c02          = field_t'(c02);
          table_out.c10          = field_t'(tally[LANE_A1_B0]);
          table_out.c11          = field_t'(tally[LANE_A1_B1]);
          table_out.c12          = field_t'(c12);
          table_out.c20          = field_t'(c20);
          table_out.c21          = field_t'(c21);
          table_out.c22          = field_t'(c22);
          table_out.inconsistent = tally_sat | neg;
          tables_due.push_back(table_out);

          foreach (tally[l]) tally[l] = '0;
          tally_sat = 1'b0;
        end
      end
      pending = tables_due.size();
    end
  end

endmodule

// File: verif/tb_genotype_pair_contingency_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_genotype_pair_contingency_counter
// Drives word transactions into the contingency counter: a directed set of
// corner words, then random groups, mostly genotype-consistent bit-planes
// with matching marginals and some noise. Both channels idle in short
// random bursts.
// ----------------------------------------------------------------------------

module tb_genotype_pair_contingency_counter;
  import gpcc_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_ITEMS  = 150;     // tail of the run without idling
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  localparam plane_t ALT_LO = {(PLANE_BITS / 4){4'h5}};
  localparam plane_t ALT_HI = {(PLANE_BITS / 4){4'hA}};

  logic clk;
  logic rst_n;
  int   err_count;
  int   tables_pending;
  int   cycles     = 0;
  int   words_sent = 0;
  int   ready_hold = 0;
  bit   quiet      = 1'b0;

  gpcc_in_if  in_chan ();
  gpcc_out_if out_chan ();

  genotype_pair_contingency_counter uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gpcc_table_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .err_count_o (err_count),
    .pending_o   (tables_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_genotype_pair_contingency_counter: errors");
      $finish;
    end
  end

  // Table receiver: ready drops at random and stays low while ready_hold counts down
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_chan.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_chan.ready <= 1'b0;
      ready_hold     <= ready_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      ready_hold     <= $urandom_range(0, 2);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // One word transaction; called and returns at a falling edge
  task automatic send_word(group_t g, plane_t a0, plane_t a1, plane_t b0, plane_t b1,
                           logic last, field_t ta0, field_t ta1, field_t ta2,
                           field_t tb0, field_t tb1);
    in_chan.valid        <= 1'b1;
    in_chan.group        <= g;
    in_chan.a_geno0_word <= a0;
    in_chan.a_geno1_word <= a1;
    in_chan.b_geno0_word <= b0;
    in_chan.b_geno1_word <= b1;
    in_chan.last_word    <= last;
    in_chan.a_total_g0   <= ta0;
    in_chan.a_total_g1   <= ta1;
    in_chan.a_total_g2   <= ta2;
    in_chan.b_total_g0   <= tb0;
    in_chan.b_total_g1   <= tb1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Sender gap now and then, with valid held low
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  function automatic field_t rand_total();
    if ($urandom_range(0, 1) != 0) return field_t'($urandom);
    return field_t'($urandom_range(0, 200));
  endfunction

  // Samples with genotypes 0..2 on both markers and true marginals;
  // spoil replaces one marginal with a random value
  task automatic send_genotype_group(group_t g, int n_words, bit spoil);
    plane_t a0, a1, b0, b1;
    int     m_a [3];
    int     m_b [3];
    field_t tot [5];
    int     n_real, ga, gb, skew;
    foreach (m_a[i]) begin
      m_a[i] = 0;
      m_b[i] = 0;
    end
    skew = $urandom_range(0, 3);  // 3 means no preferred genotype
    for (int w = 0; w < n_words; w++) begin
      a0 = '0;
      a1 = '0;
      b0 = '0;
      b1 = '0;
      n_real = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WORD_BITS) : WORD_BITS;
      for (int s = 0; s < n_real; s++) begin
        ga = (skew < 3 && $urandom_range(0, 1) != 0) ? skew : $urandom_range(0, 2);
        gb = (skew < 3 && $urandom_range(0, 1) != 0) ? skew : $urandom_range(0, 2);
        if (ga == 0) a0[s] = 1'b1;
        if (ga == 1) a1[s] = 1'b1;
        if (gb == 0) b0[s] = 1'b1;
        if (gb == 1) b1[s] = 1'b1;
        m_a[ga]++;
        m_b[gb]++;
      end
      tot = '{field_t'(m_a[0]), field_t'(m_a[1]), field_t'(m_a[2]),
              field_t'(m_b[0]), field_t'(m_b[1])};
      if (spoil) tot[$urandom_range(0, 4)] = rand_total();
      maybe_idle();
      send_word(g, a0, a1, b0, b1, w == n_words - 1,
                tot[0], tot[1], tot[2], tot[3], tot[4]);
    end
  endtask

  // Overlapping random planes, random group per word, random marginals
  task automatic send_noise_group(int n_words);
    plane_t p [4];
    for (int w = 0; w < n_words; w++) begin
      foreach (p[i]) begin
        p[i] = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) p[i] &= {$urandom, $urandom};
      end
      maybe_idle();
      send_word(group_t'($urandom), p[0], p[1], p[2], p[3], w == n_words - 1,
                rand_total(), rand_total(), rand_total(), rand_total(), rand_total());
    end
  endtask

  initial begin
    int     first_random;
    int     kind;
    group_t grp;
    in_chan.valid        = 1'b0;
    in_chan.group        = '0;
    in_chan.a_geno0_word = '0;
    in_chan.a_geno1_word = '0;
    in_chan.b_geno0_word = '0;
    in_chan.b_geno1_word = '0;
    in_chan.last_word    = 1'b0;
    in_chan.a_total_g0   = '0;
    in_chan.a_total_g1   = '0;
    in_chan.a_total_g2   = '0;
    in_chan.b_total_g0   = '0;
    in_chan.b_total_g1   = '0;
    out_chan.ready       = 1'b0;
    rst_n                = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners
    // empty table
    send_word(2'd0, '0, '0, '0, '0, 1'b1, '0, '0, '0, '0, '0);
    // every plane full, marginals at maximum
    send_word(2'd1, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1, '1);
    // marginals too small: derived cells clamp
    send_word(2'd2, '1, '0, '1, '0, 1'b1, '0, '0, '0, '0, '0);
    // two-word consistent group
    send_word(2'd3, ALT_LO, ALT_HI, ALT_LO, ALT_HI, 1'b0, '0, '0, '0, '0, '0);
    send_word(2'd3, ALT_LO, ALT_HI, ALT_LO, ALT_HI, 1'b1,
              field_t'(WORD_BITS), field_t'(WORD_BITS), '0,
              field_t'(WORD_BITS), field_t'(WORD_BITS));
    // group field changes before the last word
    send_word(2'd0, ALT_LO, ALT_LO, ALT_HI, ALT_HI, 1'b0, '1, '1, '1, '1, '1);
    send_word(2'd3, ALT_HI, ALT_LO, ALT_HI, ALT_LO, 1'b1,
              20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h55555, 20'hAAAAA);
    // top and bottom sample bits only
    send_word(2'd2, plane_t'(1) << (WORD_BITS - 1), plane_t'(1), plane_t'(1),
              plane_t'(1) << (WORD_BITS - 1), 1'b1, 20'd1, 20'd1, 20'd0, 20'd1, 20'd1);
    // empty planes, marginals at maximum: last cell goes negative
    send_word(2'd1, '0, '0, '0, '0, 1'b1, '1, '1, '1, '1, '1);
    // four groups back to back
    for (int g = 0; g < 4; g++) begin
      send_word(group_t'(g), {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, 1'b1,
                rand_total(), rand_total(), rand_total(), rand_total(), rand_total());
    end

    // Hold off until every table so far has come out
    in_chan.valid <= 1'b0;
    while (tables_pending != 0) @(negedge clk);

    // Random groups, mostly consistent, in group order
    first_random = words_sent;
    grp          = '0;
    while (words_sent < first_random + RANDOM_ITEMS) begin
      if (words_sent >= first_random + RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_genotype_group(grp, $urandom_range(1, 8), kind == 6);
      end else begin
        send_noise_group($urandom_range(1, 6));
      end
      grp = grp + 2'd1;
    end
    in_chan.valid <= 1'b0;

    // Drain
    while (tables_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && tables_pending == 0) begin
      $display("tb_genotype_pair_contingency_counter: clean");
    end else begin
      $display("tb_genotype_pair_contingency_counter: errors");
    end
    $finish;
  end

endmodule
